// ===== design/jss_pkg.sv =====
// ----------------------------------------------------------------------------
// jss_pkg: shared types and constants for the joint setpoint smoother
// Holds the field widths, register codes, request codes, the controller
// state type, the command bundle and the saturation helper.
// ----------------------------------------------------------------------------
package jss_pkg;

  localparam int NUM_JOINTS  = 3;
  localparam int JOINT_W     = 2;
  localparam int VMAX_REGS   = 3;
  localparam int Q_W         = 32;
  localparam int VMAX_W      = 31;
  localparam int DV_W        = 31;
  localparam int PERIOD_W    = 25;
  localparam int TOL_W       = 16;

  localparam int IN_TDATA_W  = 40;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 64;
  localparam int OUT_TUSER_W = 2;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;

  // Wide intermediate widths
  localparam int ERR_W       = Q_W + 1;        // target - position
  localparam int ERR8_W      = ERR_W + 3;      // 8 * error
  localparam int PROD_W      = ERR_W + PERIOD_W + 1;
  localparam int SHIFT       = 25;             // half period scaling
  localparam int STEP_W      = PROD_W - SHIFT;
  localparam int SAT_IN_W    = STEP_W + 1;

  localparam logic signed [PROD_W-1:0] ROUND_BIAS = PROD_W'(64'sd16777216);
  localparam logic signed [SAT_IN_W-1:0] Q_MAX_EXT = SAT_IN_W'(64'sd2147483647);
  localparam logic signed [SAT_IN_W-1:0] Q_MIN_EXT = SAT_IN_W'(-64'sd2147483648);

  // Register reset values
  localparam logic [VMAX_W-1:0]   VMAX_RST   = VMAX_W'(65536);
  localparam logic [DV_W-1:0]     DV_RST     = DV_W'(197);
  localparam logic [PERIOD_W-1:0] PERIOD_RST = PERIOD_W'(16777);
  localparam logic [TOL_W-1:0]    POS_TOL_RST = TOL_W'(11);
  localparam logic [TOL_W-1:0]    VEL_TOL_RST = TOL_W'(328);
  localparam logic [TOL_W-1:0]    NUDGE_RST  = TOL_W'(1144);

  typedef enum logic [IN_TUSER_W-1:0] {
    REQ_TICK       = 2'd0,
    REQ_SET_TARGET = 2'd1,
    REQ_NUDGE      = 2'd2,
    REQ_INIT       = 2'd3
  } req_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_VMAX0      = 3'd0,
    REG_VMAX1      = 3'd1,
    REG_VMAX2      = 3'd2,
    REG_DV         = 3'd3,
    REG_PERIOD     = 3'd4,
    REG_POS_TOL    = 3'd5,
    REG_VEL_TOL    = 3'd6,
    REG_NUDGE_STEP = 3'd7
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ERR,
    ST_SLEW,
    ST_MUL,
    ST_WR
  } st_t;

  typedef struct packed {
    logic [VMAX_REGS-1:0][VMAX_W-1:0] vmax;
    logic [DV_W-1:0]                  dv;
    logic [PERIOD_W-1:0]              period;
    logic [TOL_W-1:0]                 pos_tol;
    logic [TOL_W-1:0]                 vel_tol;
    logic [TOL_W-1:0]                 nudge_step;
  } cfg_t;

  typedef struct packed {
    logic               take;       // input transaction this cycle
    logic               calc_err;   // error, settle test, desired velocity
    logic               calc_slew;  // slew-limited new velocity
    logic               calc_mul;   // trapezoid product
    logic               write;      // commit joint state and emit result
    logic               last;       // final joint of the run
    logic [JOINT_W-1:0] joint;      // joint under work
  } cmd_t;

  // Saturate a wide signed value to the Q16.16 range
  function automatic logic signed [Q_W-1:0] sat_q(input logic signed [SAT_IN_W-1:0] x);
    logic signed [Q_W-1:0] r;
    if (x > Q_MAX_EXT) begin
      r = Q_MAX_EXT[Q_W-1:0];
    end else if (x < Q_MIN_EXT) begin
      r = Q_MIN_EXT[Q_W-1:0];
    end else begin
      r = x[Q_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== design/jss_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// jss_cfg_regs: configuration register bank
// Takes one register write per transaction on the configuration channel and
// masks the data to the register width.
// ----------------------------------------------------------------------------
module jss_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [jss_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [jss_pkg::CFG_DATA_W-1:0] cfg_data,
  output jss_pkg::cfg_t                 cfg
);

  jss_pkg::cfg_t cfg_r;

  // Always ready for a write
  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  // Update the addressed register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < jss_pkg::VMAX_REGS; k++) begin
        cfg_r.vmax[k] <= jss_pkg::VMAX_RST;
      end
      cfg_r.dv         <= jss_pkg::DV_RST;
      cfg_r.period     <= jss_pkg::PERIOD_RST;
      cfg_r.pos_tol    <= jss_pkg::POS_TOL_RST;
      cfg_r.vel_tol    <= jss_pkg::VEL_TOL_RST;
      cfg_r.nudge_step <= jss_pkg::NUDGE_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (jss_pkg::reg_idx_t'(cfg_index))
        jss_pkg::REG_VMAX0:      cfg_r.vmax[0]    <= cfg_data[jss_pkg::VMAX_W-1:0];
        jss_pkg::REG_VMAX1:      cfg_r.vmax[1]    <= cfg_data[jss_pkg::VMAX_W-1:0];
        jss_pkg::REG_VMAX2:      cfg_r.vmax[2]    <= cfg_data[jss_pkg::VMAX_W-1:0];
        jss_pkg::REG_DV:         cfg_r.dv         <= cfg_data[jss_pkg::DV_W-1:0];
        jss_pkg::REG_PERIOD:     cfg_r.period     <= cfg_data[jss_pkg::PERIOD_W-1:0];
        jss_pkg::REG_POS_TOL:    cfg_r.pos_tol    <= cfg_data[jss_pkg::TOL_W-1:0];
        jss_pkg::REG_VEL_TOL:    cfg_r.vel_tol    <= cfg_data[jss_pkg::TOL_W-1:0];
        jss_pkg::REG_NUDGE_STEP: cfg_r.nudge_step <= cfg_data[jss_pkg::TOL_W-1:0];
      endcase
    end
  end

endmodule

// ===== design/jss_ctrl.sv =====
// ----------------------------------------------------------------------------
// jss_ctrl: sequencing state machine
// Accepts requests while idle and walks every joint of an enabled tick
// through the four datapath steps, holding the commit while the result
// register is still occupied.
// ----------------------------------------------------------------------------
module jss_ctrl (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [jss_pkg::IN_TUSER_W-1:0] in_req_type,
  input  logic                           in_enabled,
  input  logic                           out_free,
  output jss_pkg::cmd_t                  cmd
);

  jss_pkg::st_t                 state_r, state_nxt;
  logic [jss_pkg::JOINT_W-1:0]  joint_r, joint_nxt;
  logic                         is_last;
  logic                         start;

  assign is_last = (joint_r == jss_pkg::JOINT_W'(jss_pkg::NUM_JOINTS - 1));
  assign start   = (state_r == jss_pkg::ST_IDLE) && in_tvalid &&
                   (jss_pkg::req_t'(in_req_type) == jss_pkg::REQ_TICK) && in_enabled;

  // Next state and joint counter
  always_comb begin
    state_nxt = state_r;
    joint_nxt = joint_r;
    unique case (state_r)
      jss_pkg::ST_IDLE: begin
        joint_nxt = '0;
        if (start) begin
          state_nxt = jss_pkg::ST_ERR;
        end
      end
      jss_pkg::ST_ERR:  state_nxt = jss_pkg::ST_SLEW;
      jss_pkg::ST_SLEW: state_nxt = jss_pkg::ST_MUL;
      jss_pkg::ST_MUL:  state_nxt = jss_pkg::ST_WR;
      jss_pkg::ST_WR: begin
        if (out_free) begin
          if (is_last) begin
            state_nxt = jss_pkg::ST_IDLE;
          end else begin
            state_nxt = jss_pkg::ST_ERR;
            joint_nxt = joint_r + 1'b1;
          end
        end
      end
      default: state_nxt = jss_pkg::ST_IDLE;
    endcase
  end

  // Commands to the datapath
  always_comb begin
    in_tready     = (state_r == jss_pkg::ST_IDLE);
    cmd.take      = (state_r == jss_pkg::ST_IDLE) && in_tvalid;
    cmd.calc_err  = (state_r == jss_pkg::ST_ERR);
    cmd.calc_slew = (state_r == jss_pkg::ST_SLEW);
    cmd.calc_mul  = (state_r == jss_pkg::ST_MUL);
    cmd.write     = (state_r == jss_pkg::ST_WR) && out_free;
    cmd.last      = is_last;
    cmd.joint     = joint_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= jss_pkg::ST_IDLE;
      joint_r <= '0;
    end else begin
      state_r <= state_nxt;
      joint_r <= joint_nxt;
    end
  end

  // A commit leaves for the next joint or for idle, never elsewhere
  a_wr_exit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.write |=> (state_r == jss_pkg::ST_IDLE) || (state_r == jss_pkg::ST_ERR))
    else $error("commit did not advance the sequence");

  // A stalled commit keeps the joint
  a_wr_hold: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == jss_pkg::ST_WR) && !out_free) |=>
      ((state_r == jss_pkg::ST_WR) && $stable(joint_r)))
    else $error("stalled commit lost its joint");

  // The joint counter stays inside the joint range
  a_joint_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != jss_pkg::ST_IDLE) |->
      (joint_r < jss_pkg::JOINT_W'(jss_pkg::NUM_JOINTS)))
    else $error("joint counter out of range");

endmodule

// ===== design/jss_datapath.sv =====
// ----------------------------------------------------------------------------
// jss_datapath: joint state and tick arithmetic
// Keeps target, position and velocity per joint, applies set, nudge and init
// requests, and computes one joint update in four steps sharing a single
// multiplier. Results leave through an output register.
// ----------------------------------------------------------------------------
module jss_datapath (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  jss_pkg::cmd_t                        cmd,
  input  jss_pkg::cfg_t                        cfg,
  input  logic [jss_pkg::IN_TUSER_W-1:0]       in_req_type,
  input  logic [jss_pkg::JOINT_W-1:0]          in_joint_index,
  input  logic signed [jss_pkg::Q_W-1:0]       in_value,
  input  logic                                 in_negative,
  input  logic                                 in_enabled,
  output logic                                 out_free,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [jss_pkg::JOINT_W-1:0]          out_joint,
  output logic signed [jss_pkg::Q_W-1:0]       out_position,
  output logic signed [jss_pkg::Q_W-1:0]       out_velocity,
  output logic                                 out_last
);

  localparam int QW = jss_pkg::Q_W;
  localparam int EW = jss_pkg::ERR_W;
  localparam int SW = jss_pkg::SAT_IN_W;

  // Joint state
  logic signed [QW-1:0] tgt_r [jss_pkg::NUM_JOINTS];
  logic signed [QW-1:0] pos_r [jss_pkg::NUM_JOINTS];
  logic signed [QW-1:0] vel_r [jss_pkg::NUM_JOINTS];

  // Step registers
  logic                              settled_r, settled_nxt;
  logic signed [QW-1:0]              desired_r, desired_nxt;
  logic signed [QW-1:0]              nvel_r, nvel_nxt;
  logic signed [jss_pkg::PROD_W-1:0] prod_r, prod_nxt;

  // Output register
  logic                        out_valid_r;
  logic [jss_pkg::JOINT_W-1:0] out_joint_r;
  logic signed [QW-1:0]        out_pos_r;
  logic signed [QW-1:0]        out_vel_r;
  logic                        out_last_r;

  logic signed [QW-1:0]  cur_tgt, cur_pos, cur_vel;
  logic [jss_pkg::VMAX_W-1:0] vmax_sel;
  logic signed [EW-1:0]  err;
  logic [EW-1:0]         abs_err;
  logic [QW-1:0]         abs_vel;
  logic signed [jss_pkg::ERR8_W-1:0] err8, vmax_ext;
  logic signed [EW-1:0]  diff, dv_ext, slew;
  logic signed [EW-1:0]  vsum;
  logic signed [jss_pkg::PROD_W-1:0] rounded;
  logic signed [jss_pkg::STEP_W-1:0] step;
  logic signed [QW-1:0]  new_pos, new_vel;
  logic                  joint_ok;
  logic signed [SW-1:0]  nudged;

  assign cur_tgt = tgt_r[cmd.joint];
  assign cur_pos = pos_r[cmd.joint];
  assign cur_vel = vel_r[cmd.joint];

  // Joints past the last clamp register share it
  assign vmax_sel = (cmd.joint >= jss_pkg::JOINT_W'(jss_pkg::VMAX_REGS - 1)) ?
                    cfg.vmax[jss_pkg::VMAX_REGS-1] : cfg.vmax[cmd.joint];

  // Error, settle test and clamped desired velocity
  always_comb begin
    err      = EW'(cur_tgt) - EW'(cur_pos);
    abs_err  = err[EW-1] ? EW'(-err) : EW'(err);
    abs_vel  = cur_vel[QW-1] ? QW'(-cur_vel) : QW'(cur_vel);
    settled_nxt = (abs_err <= EW'(cfg.pos_tol)) && (abs_vel <= QW'(cfg.vel_tol));
    err8     = {err, 3'b000};
    vmax_ext = $signed({{(jss_pkg::ERR8_W - jss_pkg::VMAX_W){1'b0}}, vmax_sel});
    if (err8 > vmax_ext) begin
      desired_nxt = QW'(vmax_ext);
    end else if (err8 < -vmax_ext) begin
      desired_nxt = QW'(-vmax_ext);
    end else begin
      desired_nxt = QW'(err8);
    end
  end

  // Slew the velocity toward the desired value
  always_comb begin
    diff   = EW'(desired_r) - EW'(cur_vel);
    dv_ext = $signed({{(EW - jss_pkg::DV_W){1'b0}}, cfg.dv});
    if (diff > dv_ext) begin
      slew = dv_ext;
    end else if (diff < -dv_ext) begin
      slew = -dv_ext;
    end else begin
      slew = diff;
    end
    nvel_nxt = QW'(EW'(cur_vel) + slew);
  end

  // Trapezoid product of summed velocities and period
  always_comb begin
    vsum     = EW'(cur_vel) + EW'(nvel_r);
    prod_nxt = jss_pkg::PROD_W'(vsum) *
               jss_pkg::PROD_W'($signed({1'b0, cfg.period}));
  end

  // Round the half-period step and integrate the position
  always_comb begin
    rounded = prod_r + jss_pkg::ROUND_BIAS;
    step    = rounded[jss_pkg::PROD_W-1:jss_pkg::SHIFT];
    if (settled_r) begin
      new_pos = cur_tgt;
      new_vel = '0;
    end else begin
      new_pos = jss_pkg::sat_q(SW'(cur_pos) + SW'(step));
      new_vel = nvel_r;
    end
  end

  // Request decode helpers
  assign joint_ok = (in_joint_index < jss_pkg::JOINT_W'(jss_pkg::NUM_JOINTS));
  assign nudged   = in_negative ?
                    SW'(tgt_r[in_joint_index]) - SW'($signed({1'b0, cfg.nudge_step})) :
                    SW'(tgt_r[in_joint_index]) + SW'($signed({1'b0, cfg.nudge_step}));

  // Step registers
  always_ff @(posedge clk) begin
    if (cmd.calc_err) begin
      settled_r <= settled_nxt;
      desired_r <= desired_nxt;
    end
    if (cmd.calc_slew) begin
      nvel_r <= nvel_nxt;
    end
    if (cmd.calc_mul) begin
      prod_r <= prod_nxt;
    end
  end

  // Joint state: requests on accept, updates on commit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < jss_pkg::NUM_JOINTS; k++) begin
        tgt_r[k] <= '0;
        pos_r[k] <= '0;
        vel_r[k] <= '0;
      end
    end else begin
      if (cmd.take) begin
        unique case (jss_pkg::req_t'(in_req_type))
          jss_pkg::REQ_TICK: begin
            if (!in_enabled) begin
              for (int k = 0; k < jss_pkg::NUM_JOINTS; k++) begin
                vel_r[k] <= '0;
              end
            end
          end
          jss_pkg::REQ_SET_TARGET: begin
            if (joint_ok) begin
              tgt_r[in_joint_index] <= in_value;
            end
          end
          jss_pkg::REQ_NUDGE: begin
            if (joint_ok) begin
              tgt_r[in_joint_index] <= jss_pkg::sat_q(nudged);
            end
          end
          jss_pkg::REQ_INIT: begin
            if (joint_ok) begin
              tgt_r[in_joint_index] <= in_value;
              pos_r[in_joint_index] <= in_value;
              vel_r[in_joint_index] <= '0;
            end
          end
        endcase
      end
      if (cmd.write) begin
        pos_r[cmd.joint] <= new_pos;
        vel_r[cmd.joint] <= new_vel;
      end
    end
  end

  // Output register: load on commit, drop on transaction
  assign out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.write) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.write) begin
      out_joint_r <= cmd.joint;
      out_pos_r   <= new_pos;
      out_vel_r   <= new_vel;
      out_last_r  <= cmd.last;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_joint    = out_joint_r;
  assign out_position = out_pos_r;
  assign out_velocity = out_vel_r;
  assign out_last     = out_last_r;

  // A commit never overwrites a result that has not left
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.write |-> (!out_valid_r || out_ready))
    else $error("result overwritten before transaction");

  // A settled joint leaves at zero velocity
  a_settle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.write && settled_r) |=> (out_vel_r == '0))
    else $error("settled joint with nonzero velocity");

  // The slewed velocity lies between the old and the desired velocity
  a_slew_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.calc_mul |->
      ((desired_r >= cur_vel) ? ((nvel_r >= cur_vel) && (nvel_r <= desired_r))
                              : ((nvel_r <= cur_vel) && (nvel_r >= desired_r))))
    else $error("slewed velocity out of bounds");

endmodule

// ===== design/joint_setpoint_smoother.sv =====
// ----------------------------------------------------------------------------
// joint_setpoint_smoother: acceleration-limited setpoints for three joints
// Top level joining the register bank, the sequencer and the datapath.
// ----------------------------------------------------------------------------
// Set-target, nudge, init and disabled-tick requests take effect in the cycle
// of their transaction and emit nothing. An enabled tick emits one result per
// joint in joint order, tlast on the final joint; each joint goes through four
// steps (error and clamp, slew, multiply, round and commit) on one shared
// datapath with one multiplier. An enabled tick holds the input off until the
// final joint commits; each commit waits while the result register is full.
// The next request is accepted while the last result still waits in the output
// register.
module joint_setpoint_smoother (
  input  logic                            clk,
  input  logic                            rst_n,
  // request stream
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // tdata: [1:0] joint_index, [33:2] value, [34] negative, [35] enabled, zero pad
  input  logic [jss_pkg::IN_TDATA_W-1:0]  in_tdata,
  // tuser: [1:0] req_type
  input  logic [jss_pkg::IN_TUSER_W-1:0]  in_tuser,
  // result stream
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // tdata: [31:0] position_command, [63:32] velocity_command
  output logic [jss_pkg::OUT_TDATA_W-1:0] out_tdata,
  // tuser: [1:0] out_joint
  output logic [jss_pkg::OUT_TUSER_W-1:0] out_tuser,
  output logic                            out_tlast,
  // configuration writes
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [jss_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [jss_pkg::CFG_DATA_W-1:0]  cfg_data
);

  jss_pkg::cfg_t              cfg;
  jss_pkg::cmd_t              cmd;
  logic                       out_free;
  logic [jss_pkg::JOINT_W-1:0] in_joint_index;
  logic signed [jss_pkg::Q_W-1:0] in_value;
  logic                       in_negative;
  logic                       in_enabled;
  logic signed [jss_pkg::Q_W-1:0] out_position;
  logic signed [jss_pkg::Q_W-1:0] out_velocity;

  // Unpack the request fields
  assign in_joint_index = in_tdata[1:0];
  assign in_value       = in_tdata[33:2];
  assign in_negative    = in_tdata[34];
  assign in_enabled     = in_tdata[35];

  // Pack the result fields
  assign out_tdata = {out_velocity, out_position};

  jss_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  jss_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_req_type (in_tuser),
    .in_enabled  (in_enabled),
    .out_free    (out_free),
    .cmd         (cmd)
  );

  jss_datapath u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .cfg            (cfg),
    .in_req_type    (in_tuser),
    .in_joint_index (in_joint_index),
    .in_value       (in_value),
    .in_negative    (in_negative),
    .in_enabled     (in_enabled),
    .out_free       (out_free),
    .out_valid      (out_tvalid),
    .out_ready      (out_tready),
    .out_joint      (out_tuser),
    .out_position   (out_position),
    .out_velocity   (out_velocity),
    .out_last       (out_tlast)
  );

endmodule
